### hdl/alc_pkg.sv
// shared types, constants and table functions for the ambient light lux calculator
`timescale 1ns / 1ps
package alc_pkg;

    localparam int RATIO_FRAC_BITS_DEF = 16;
    localparam int POW_TABLE_DEPTH_DEF = 256;

    // q0.20 coefficients per segment
    localparam logic [31:0] C1A = 32'd31877;
    localparam logic [31:0] C1B = 32'd65012;
    localparam logic [31:0] C2A = 32'd23488;
    localparam logic [31:0] C2B = 32'd32506;
    localparam logic [31:0] C3A = 32'd13422;
    localparam logic [31:0] C3B = 32'd16043;
    localparam logic [31:0] C4A = 32'd1531;
    localparam logic [31:0] C4B = 32'd1174;

    localparam logic [10:0] LUX_MAX = 11'd2047;

    // segment codes
    localparam logic [2:0] SEG_NONE = 3'd0;
    localparam logic [2:0] SEG_ONE = 3'd1;
    localparam logic [2:0] SEG_TWO = 3'd2;
    localparam logic [2:0] SEG_THREE = 3'd3;
    localparam logic [2:0] SEG_FOUR = 3'd4;

    // register byte addresses
    localparam logic [2:0] ADDR_MAX_DISPLAY = 3'd0;
    localparam logic [2:0] ADDR_MIN_VISIBLE = 3'd4;

    typedef struct packed {
        logic [15:0] ch0_count;
        logic [15:0] ch1_count;
    } alc_in_t;

    typedef struct packed {
        logic [10:0] lux;
        logic [2:0]  ratio_region;
        logic [7:0]  display_level;
    } alc_out_t;

    // data that rides along with the ratio through the divider and table
    typedef struct packed {
        logic [2:0]  region;
        logic [31:0] a;
        logic [31:0] b;
    } alc_sb_t;

    // truncating q0.32 product
    function automatic logic [63:0] q32_mul(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] p;
        p = {32'd0, x[31:0]} * {32'd0, y[31:0]};
        return p >> 32;
    endfunction

    // x^1.4 in q0.32 for x in q0.32, built at elaboration
    function automatic logic [31:0] pow_entry(input logic [63:0] x);
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] t4;
        logic [63:0] t5;
        logic [63:0] r;
        y = q32_mul(x, x);
        z = 64'd0;
        for (int bitn = 31; bitn >= 0; bitn--)
        begin
            t = z | (64'd1 << bitn);
            t2 = q32_mul(t, t);
            t4 = q32_mul(t2, t2);
            t5 = q32_mul(t4, t);
            if (t5 <= y)
            begin
                z = t;
            end
        end
        r = q32_mul(x, z);
        return r[31:0];
    endfunction

endpackage

### hdl/ambient_light_lux_calc.sv
// top level of the ambient light lux calculator
`timescale 1ns / 1ps
// Takes one beat of two channel counts per cycle unless stalled and returns lux,
// segment and display level. The divider resolves one ratio bit per stage, and
// a new beat enters every cycle unless stalled. The whole pipeline holds while
// out_stall is high with a result waiting, and in_stall follows it. Registers:
// byte address 0 max_display_level, 4 min_visible_level; bit 2 of paddr selects.
module ambient_light_lux_calc import alc_pkg::*; #(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
    parameter int POW_TABLE_DEPTH = POW_TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  alc_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output alc_out_t    out_data
);

    logic [7:0] max_reg;
    logic [7:0] min_reg;
    logic       en;

    // config registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= 8'd255;
            min_reg <= 8'd1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
            begin
                min_reg <= pwdata[7:0];
            end
            else
            begin
                max_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = {24'd0, paddr[2] ? min_reg : max_reg};

    // whole pipeline advances unless the output beat is held
    assign en = !(out_valid && out_stall);
    assign in_stall = !en;

    // segment select and linear terms
    logic [15:0] ch0;
    logic [15:0] ch1;
    logic [19:0] c1x2;
    logic [23:0] c1x100;
    logic [23:0] c0x61;
    logic [18:0] c1x5;
    logic [18:0] c0x4;
    logic [19:0] c1x10;
    logic [19:0] c0x13;
    alc_sb_t     sb_next;

    assign ch0 = in_data.ch0_count;
    assign ch1 = in_data.ch1_count;
    assign c1x2 = {3'd0, ch1, 1'b0};
    assign c1x100 = 24'(ch1) * 24'd100;
    assign c0x61 = 24'(ch0) * 24'd61;
    assign c1x5 = 19'(ch1) * 19'd5;
    assign c0x4 = {1'b0, ch0, 2'b00};
    assign c1x10 = 20'(ch1) * 20'd10;
    assign c0x13 = 20'(ch0) * 20'd13;

    always_comb
    begin
        sb_next.region = SEG_NONE;
        sb_next.a = '0;
        sb_next.b = '0;
        if (ch0 != 16'd0 && ch1 != 16'd0)
        begin
            if (c1x2 <= 20'(ch0))
            begin
                sb_next.region = SEG_ONE;
                sb_next.a = C1A * 32'(ch0);
                sb_next.b = C1B * 32'(ch0);
            end
            else if (c1x100 <= c0x61)
            begin
                sb_next.region = SEG_TWO;
                sb_next.a = C2A * 32'(ch0);
                sb_next.b = C2B * 32'(ch1);
            end
            else if (c1x5 <= c0x4)
            begin
                sb_next.region = SEG_THREE;
                sb_next.a = C3A * 32'(ch0);
                sb_next.b = C3B * 32'(ch1);
            end
            else if (c1x10 <= c0x13)
            begin
                sb_next.region = SEG_FOUR;
                sb_next.a = C4A * 32'(ch0);
                sb_next.b = C4B * 32'(ch1);
            end
        end
    end

    logic        s1_valid_reg;
    alc_sb_t     s1_sb_reg;
    logic [15:0] s1_num_reg;
    logic [15:0] s1_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sb_reg <= sb_next;
            s1_num_reg <= (sb_next.region == SEG_ONE) ? ch1 : 16'd0;
            s1_den_reg <= ch0;
        end
    end

    // ratio divider
    logic                       d_valid;
    logic [RATIO_FRAC_BITS-1:0] d_quot;
    alc_sb_t                    d_sb;

    alc_div #(.FRAC(RATIO_FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .num       (s1_num_reg),
        .den       (s1_den_reg),
        .in_sb     (s1_sb_reg),
        .out_valid (d_valid),
        .quot      (d_quot),
        .out_sb    (d_sb)
    );

    // ratio^1.4
    logic        p_valid;
    logic [31:0] p_pow;
    alc_sb_t     p_sb;

    alc_pow #(.FRAC(RATIO_FRAC_BITS), .DEPTH(POW_TABLE_DEPTH)) u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .ratio     (d_quot),
        .in_sb     (d_sb),
        .out_valid (p_valid),
        .pow       (p_pow),
        .out_sb    (p_sb)
    );

    // subtrahend product for segment one
    logic        m_valid_reg;
    logic [2:0]  m_region_reg;
    logic [31:0] m_a_reg;
    logic [31:0] m_b_reg;
    logic [63:0] m_prod;

    assign m_prod = {32'd0, p_sb.b} * {32'd0, p_pow};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= p_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_region_reg <= p_sb.region;
            m_a_reg <= p_sb.a;
            m_b_reg <= (p_sb.region == SEG_ONE) ? m_prod[63:32] : p_sb.b;
        end
    end

    // lux clamp and display level
    logic [32:0] diff;
    logic [10:0] lux;
    logic [7:0]  disp;

    assign diff = {1'b0, m_a_reg} - {1'b0, m_b_reg};

    always_comb
    begin
        if (diff[32] || diff == 33'd0)
        begin
            lux = 11'd0;
        end
        else if (diff[31:20] > {1'b0, LUX_MAX})
        begin
            lux = LUX_MAX;
        end
        else
        begin
            lux = diff[30:20];
        end
    end

    always_comb
    begin
        if (lux < {3'd0, max_reg} && lux > {3'd0, min_reg})
        begin
            disp = lux[7:0];
        end
        else if (lux < {3'd0, min_reg})
        begin
            disp = max_reg;
        end
        else if (lux > {3'd0, max_reg})
        begin
            disp = min_reg;
        end
        else
        begin
            disp = 8'd0;
        end
    end

    logic     out_valid_reg;
    alc_out_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.lux <= lux;
            out_reg.ratio_region <= m_region_reg;
            out_reg.display_level <= disp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

`ifndef SYNTHESIS
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held output beat");
    a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.ratio_region <= SEG_FOUR))
        else $error("segment code out of range");
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.ratio_region == SEG_NONE) |-> (out_data.lux == 11'd0))
        else $error("nonzero lux without a segment");
`endif

endmodule

### hdl/alc_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module alc_div import alc_pkg::*; #(
    parameter int FRAC = RATIO_FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [15:0]     num,
    input  logic [15:0]     den,
    input  alc_sb_t         in_sb,
    output logic            out_valid,
    output logic [FRAC-1:0] quot,
    output alc_sb_t         out_sb
);

    logic [15:0]     rem_reg [FRAC+1];
    logic [FRAC-1:0] quot_reg [FRAC+1];
    logic [15:0]     den_reg [FRAC+1];
    alc_sb_t         sb_reg [FRAC+1];
    logic [FRAC:0]   valid_reg;

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            quot_reg[0] <= '0;
            den_reg[0] <= den;
            sb_reg[0] <= in_sb;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= FRAC; k++)
    begin : g_stage
        logic [16:0] trial;
        logic        ge;
        logic [16:0] diff;

        assign trial = {rem_reg[k-1], 1'b0};
        assign ge = trial >= {1'b0, den_reg[k-1]};
        assign diff = trial - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[15:0] : trial[15:0];
                quot_reg[k] <= {quot_reg[k-1][FRAC-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[FRAC];
    assign quot = quot_reg[FRAC];
    assign out_sb = sb_reg[FRAC];

endmodule

### hdl/alc_pow.sv
// ratio^1.4 by linear interpolation in a constant table, three stages
`timescale 1ns / 1ps
module alc_pow import alc_pkg::*; #(
    parameter int FRAC  = RATIO_FRAC_BITS_DEF,
    parameter int DEPTH = POW_TABLE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [FRAC-1:0] ratio,
    input  alc_sb_t         in_sb,
    output logic            out_valid,
    output logic [31:0]     pow,
    output alc_sb_t         out_sb
);

    localparam int MUL_W = $clog2(2 * DEPTH) + 1;
    localparam int POS_W = FRAC + MUL_W;
    localparam int IDX_W = POS_W - FRAC;
    localparam int TAB_W = $clog2(DEPTH + 1);

    logic [31:0] tab [DEPTH+1];

    // constant table over [0, 0.5]
    for (genvar i = 0; i <= DEPTH; i++)
    begin : g_tab
        localparam logic [63:0] X = (64'(i) << 31) / DEPTH;
        localparam logic [31:0] E = pow_entry(X);
        assign tab[i] = E;
    end

    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] idx;
    logic [FRAC-1:0]  frac;
    logic [TAB_W-1:0] idx_lo;
    logic [31:0]      lo;
    logic [31:0]      hi;
    logic             over;

    assign pos = POS_W'(ratio) * POS_W'(2 * DEPTH);
    assign idx = pos[POS_W-1:FRAC];
    assign over = idx >= IDX_W'(DEPTH);
    assign idx_lo = over ? TAB_W'(DEPTH) : idx[TAB_W-1:0];
    assign frac = over ? '0 : pos[FRAC-1:0];
    assign lo = tab[idx_lo];
    assign hi = over ? lo : tab[idx_lo + TAB_W'(1)];

    logic [2:0]      valid_reg;
    logic [31:0]     lo1_reg;
    logic [31:0]     span_reg;
    logic [FRAC-1:0] frac_reg;
    logic [31:0]     lo2_reg;
    logic [31+FRAC:0] prod_reg;
    logic [31:0]     pow_reg;
    alc_sb_t         sb_reg [3];

    logic [31+FRAC:0] prod_next;
    logic [31:0]      pow_next;

    assign prod_next = {{FRAC{1'b0}}, span_reg} * {32'd0, frac_reg};
    assign pow_next = lo2_reg + prod_reg[31+FRAC:FRAC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // table read, span product, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo1_reg <= lo;
            span_reg <= (hi < lo) ? 32'd0 : hi - lo;
            frac_reg <= frac;
            sb_reg[0] <= in_sb;
            lo2_reg <= lo1_reg;
            prod_reg <= prod_next;
            sb_reg[1] <= sb_reg[0];
            pow_reg <= pow_next;
            sb_reg[2] <= sb_reg[1];
        end
    end

    assign out_valid = valid_reg[2];
    assign pow = pow_reg;
    assign out_sb = sb_reg[2];

endmodule
